### rtl/core/cse_pkg.sv
package cse_pkg;

    // Fixed field widths
    localparam int KEY_W = 8;

    // Defaults for the top-level parameters
    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_COUNT_DEF = 256;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLR,
        ST_LOAD,
        ST_INC,
        ST_RD,
        ST_GET,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;   // write zero at scan address, step on
        logic key_take;   // input word accepted
        logic inc_wr;     // write back incremented count
        logic scan_rd;    // read count at scan address
        logic scan_get;   // capture count, clear entry
        logic emit_step;  // output word accepted
        logic set_done;   // set finished, clear set state
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic room;        // key store not yet full
        logic in_last;     // last flag on the incoming word
        logic last_held;   // last flag of the word just taken
        logic addr_last;   // scan address at top of key range
        logic rd_zero;     // count read back is zero
        logic rep_one;     // one copy of current key left
        logic final_word;  // current output word closes the set
    } t_sts;

endpackage

### rtl/core/cse_if.sv
// Key input channel
interface cse_key_if;
    import cse_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_value;
    logic             last_key;

    modport source (output valid, output key_value, output last_key, input ready);
    modport sink   (input valid, input key_value, input last_key, output ready);
endinterface

// Sorted result channel
interface cse_res_if;
    import cse_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sorted_key;
    logic             last_sorted;
    logic             overflow_flag;

    modport source (output valid, output sorted_key, output last_sorted,
                    output overflow_flag, input ready);
    modport sink   (input valid, input sorted_key, input last_sorted,
                    input overflow_flag, output ready);
endinterface

### rtl/core/cse_ram.sv
module cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/cse_dp.sv
module cse_dp #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_COUNT = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cse_pkg::t_cmd            i_cmd,
    output cse_pkg::t_sts            o_sts,
    input  logic [cse_pkg::KEY_W-1:0] i_key_value,
    input  logic                     i_last_key,
    output logic [cse_pkg::KEY_W-1:0] o_sorted_key,
    output logic                     o_last_sorted,
    output logic                     o_overflow_flag
);
    import cse_pkg::*;

    // Only key values below 2**KEY_W can occur
    localparam int KEY_SPAN = (KEY_COUNT < (1 << KEY_W)) ? KEY_COUNT : (1 << KEY_W);
    localparam int AW       = (KEY_SPAN > 1) ? $clog2(KEY_SPAN) : 1;
    localparam int CW       = $clog2(MAX_ITEMS + 1);

    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_key;
    logic [CW-1:0] r_items, n_items;
    logic [CW-1:0] r_emitted, n_emitted;
    logic [CW-1:0] r_rep;
    logic          r_ovf, n_ovf;
    logic          r_last;

    logic [AW-1:0] key_clamped;
    logic [CW-1:0] rd_data;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [CW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic          room;
    logic          adv;

    // Saturate keys beyond the key range
    always_comb begin
        if ({1'b0, i_key_value} >= (KEY_W + 1)'(KEY_SPAN)) begin
            key_clamped = AW'(KEY_SPAN - 1);
        end else begin
            key_clamped = AW'(i_key_value);
        end
    end

    assign room = (r_items < CW'(MAX_ITEMS));

    // Count table port steering
    always_comb begin
        ram_rd_en   = (i_cmd.key_take & room) | i_cmd.scan_rd;
        ram_rd_addr = i_cmd.key_take ? key_clamped : r_addr;
        ram_wr_en   = i_cmd.clr_step | i_cmd.inc_wr | i_cmd.scan_get;
        ram_wr_addr = i_cmd.inc_wr ? r_key : r_addr;
        ram_wr_data = i_cmd.inc_wr ? (rd_data + CW'(1)) : '0;
    end

    cse_ram #(
        .WIDTH (CW),
        .DEPTH (KEY_SPAN)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    // Set bookkeeping and scan pointer
    always_comb begin
        adv       = i_cmd.clr_step | (i_cmd.scan_get & (rd_data == '0))
                  | (i_cmd.emit_step & (r_rep == CW'(1)));
        n_addr    = adv ? (r_addr + AW'(1)) : r_addr;
        n_items   = r_items;
        n_ovf     = r_ovf;
        n_emitted = i_cmd.emit_step ? (r_emitted + CW'(1)) : r_emitted;
        if (i_cmd.key_take) begin
            if (room) begin
                n_items = r_items + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.set_done) begin
            n_addr    = '0;
            n_items   = '0;
            n_ovf     = 1'b0;
            n_emitted = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_items   <= '0;
            r_ovf     <= 1'b0;
            r_emitted <= '0;
            r_last    <= 1'b0;
        end else begin
            r_addr    <= n_addr;
            r_items   <= n_items;
            r_ovf     <= n_ovf;
            r_emitted <= n_emitted;
            if (i_cmd.key_take) begin
                r_last <= i_last_key;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_take) begin
            r_key <= key_clamped;
        end
        if (i_cmd.scan_get) begin
            r_rep <= rd_data;
        end else if (i_cmd.emit_step) begin
            r_rep <= r_rep - CW'(1);
        end
    end

    // Status
    always_comb begin
        o_sts.room       = room;
        o_sts.in_last    = i_last_key;
        o_sts.last_held  = r_last;
        o_sts.addr_last  = (r_addr == AW'(KEY_SPAN - 1));
        o_sts.rd_zero    = (rd_data == '0);
        o_sts.rep_one    = (r_rep == CW'(1));
        o_sts.final_word = ((r_emitted + CW'(1)) == r_items);
    end

    assign o_sorted_key    = KEY_W'(r_addr);
    assign o_last_sorted   = o_sts.final_word;
    assign o_overflow_flag = r_ovf;

endmodule

### rtl/core/cse_ctrl.sv
module cse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cse_pkg::t_sts i_sts,
    output cse_pkg::t_cmd o_cmd
);
    import cse_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.addr_last) begin
                    o_cmd.set_done = 1'b1;
                    n_state        = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.key_take = 1'b1;
                    if (i_sts.room) begin
                        n_state = ST_INC;
                    end else if (i_sts.in_last) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_INC: begin
                o_cmd.inc_wr = 1'b1;
                n_state      = i_sts.last_held ? ST_RD : ST_LOAD;
            end
            ST_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_GET;
            end
            ST_GET: begin
                o_cmd.scan_get = 1'b1;
                n_state        = i_sts.rd_zero ? ST_RD : ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_sts.final_word) begin
                        o_cmd.set_done = 1'b1;
                        n_state        = ST_LOAD;
                    end else if (i_sts.rep_one) begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    // Input and output sides never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open at once");

    // A counted key without last mark returns to loading
    a_inc_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INC && !i_sts.last_held) |=> (r_state == ST_LOAD))
        else $error("count update did not return to load");

    // Final word of a set reopens the input
    a_set_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_sts.final_word) |=> (r_state == ST_LOAD))
        else $error("set end did not reopen input");

    // Clear sweep only leaves at the top address
    a_clr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR && !i_sts.addr_last) |=> (r_state == ST_CLR))
        else $error("clear sweep left early");

endmodule

### rtl/core/counting_sort_engine.sv
// Channel   Dir  Payload                                  Handshake
// i_key     in   key_value[7:0], last_key                 valid/ready
// o_res     out  sorted_key[7:0], last_sorted, overflow   valid/ready
//
// A stored key gets a count read (ST_LOAD) and write (ST_INC); a dropped key is only
// accepted. After the last key the count table is scanned from key 0 up to the largest
// key present: each value is read (ST_RD) and captured (ST_GET), then its words are
// emitted (ST_EMIT). Reset starts a sweep of all min(KEY_COUNT, 256) entries that
// zeroes the count table; no key is taken until it ends. The scan clears the table for
// the next set. Output stalls simply hold the scan; input is closed while a set is emitted.
module counting_sort_engine #(
    parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF,
    parameter int KEY_COUNT = cse_pkg::KEY_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cse_key_if.sink    i_key,
    cse_res_if.source  o_res
);
    import cse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cse_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_COUNT (KEY_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_key_value     (i_key.key_value),
        .i_last_key      (i_key.last_key),
        .o_sorted_key    (o_res.sorted_key),
        .o_last_sorted   (o_res.last_sorted),
        .o_overflow_flag (o_res.overflow_flag)
    );

endmodule

### test/counting_sort_engine_tb.sv
`timescale 1ns / 100ps

module counting_sort_engine_tb;
    import cse_pkg::*;

    localparam int MAX_KEYS  = MAX_ITEMS_DEF;
    localparam int KEY_CNT   = KEY_COUNT_DEF;
    localparam int RAND_KEYS = 420;
    localparam int MAX_WAIT  = 18;
    // full scan of the count table plus a set of words, with some slack
    localparam int DRAIN_CYC = 2 * KEY_CNT + MAX_KEYS + 64;
    localparam int N_DIR     = 25;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             ovf;
    } t_sorted_word;

    // one row per key; typed rows carry the single word they must produce
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             typed;
        t_sorted_word     want;
    } t_dir_row;

    typedef enum int {PAT_ANY, PAT_NARROW, PAT_EDGE, PAT_FALLING} t_key_pat;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{8'd0,   1'b1, 1'b1, '{8'd0,   1'b1, 1'b0}},
        '{8'd255, 1'b1, 1'b1, '{8'd255, 1'b1, 1'b0}},
        '{8'd128, 1'b1, 1'b1, '{8'd128, 1'b1, 1'b0}},
        '{8'd200, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd3,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd255, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd0,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd3,   1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd9,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd9,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd9,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd9,   1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd1,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd2,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd4,   1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd8,   1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd250, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd200, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd150, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd100, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd50,  1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd1,   1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'h55,  1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'hAA,  1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
        '{8'd127, 1'b1, 1'b1, '{8'd127, 1'b1, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cse_key_if key_if ();
    cse_res_if res_if ();

    counting_sort_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if.sink),
        .o_res   (res_if.source)
    );

    always #2 i_clk = ~i_clk;

    // sort model state: per-value tallies of the set being collected
    int unsigned  key_tally [KEY_CNT];
    int           held_n;
    bit           dropped;
    t_sorted_word sorted_due [$];

    int n_keys, n_sets, n_ovf_sets, n_words, n_err;
    bit src_calm, sink_calm;

    function automatic logic [KEY_W-1:0] clamp_key(input logic [KEY_W-1:0] k);
        return (k >= KEY_CNT) ? KEY_W'(KEY_CNT - 1) : k;
    endfunction

    // Counts one key; on the last key of a set gives the sorted words
    task automatic sort_model(input logic [KEY_W-1:0] k, input logic l,
                              output t_sorted_word words [$]);
        logic [KEY_W-1:0] ck;
        int               c;
        t_sorted_word     w;
        ck    = clamp_key(k);
        words = {};
        n_keys++;
        if (held_n < MAX_KEYS) begin
            key_tally[ck]++;
            held_n++;
        end else begin
            dropped = 1'b1;
        end
        if (l) begin
            c = 0;
            for (int v = 0; v < KEY_CNT; v++) begin
                for (int r = 0; r < key_tally[v]; r++) begin
                    c++;
                    w.key  = KEY_W'(v);
                    w.last = (c == held_n);
                    w.ovf  = dropped;
                    words.push_back(w);
                end
                key_tally[v] = 0;
            end
            n_sets++;
            if (dropped)
                n_ovf_sets++;
            held_n  = 0;
            dropped = 1'b0;
        end
    endtask

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Offers one key word and returns at the edge where it is taken
    task automatic send_key(input logic [KEY_W-1:0] k, input logic l);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_if.valid     <= 1'b1;
        key_if.key_value <= k;
        key_if.last_key  <= l;
        do @(posedge i_clk); while (!key_if.ready);
    endtask

    // Sends a key and files what the sort should emit for it
    task automatic feed_key(input logic [KEY_W-1:0] k, input logic l);
        t_sorted_word words [$];
        send_key(k, l);
        sort_model(k, l, words);
        foreach (words[i])
            sorted_due.push_back(words[i]);
    endtask

    // Result side: random stalls, field-by-field compare against the oldest word due
    initial begin
        int           stall;
        t_sorted_word want;
        res_if.ready <= 1'b0;
        sink_calm = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (n_words % 24 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            n_words++;
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got key %0d last %0b ovf %0b",
                         $time, res_if.sorted_key, res_if.last_sorted,
                         res_if.overflow_flag);
                n_err++;
            end else begin
                want = sorted_due.pop_front();
                if (res_if.sorted_key !== want.key) begin
                    $display("%0t: sorted_key mismatch, expected %0d, got %0d",
                             $time, want.key, res_if.sorted_key);
                    n_err++;
                end
                if (res_if.last_sorted !== want.last) begin
                    $display("%0t: last_sorted mismatch, expected %0b, got %0b",
                             $time, want.last, res_if.last_sorted);
                    n_err++;
                end
                if (res_if.overflow_flag !== want.ovf) begin
                    $display("%0t: overflow_flag mismatch, expected %0b, got %0b",
                             $time, want.ovf, res_if.overflow_flag);
                    n_err++;
                end
            end
        end
    end

    // Stimulus: directed table, then random sets
    initial begin
        t_sorted_word     words [$];
        int               set_i;
        int               size;
        int               n_rand;
        int               pick;
        t_key_pat         pat;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] k;
        int               scripted [3];

        scripted = '{MAX_KEYS, MAX_KEYS + 1, MAX_KEYS + 6};
        held_n   = 0;
        dropped  = 1'b0;
        foreach (key_tally[v])
            key_tally[v] = 0;
        src_calm = 1'b0;

        i_rst_n          <= 1'b0;
        key_if.valid     <= 1'b0;
        key_if.key_value <= '0;
        key_if.last_key  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; typed rows replace the model's word with the literal one
        foreach (DIR_ROWS[r]) begin
            send_key(DIR_ROWS[r].key, DIR_ROWS[r].last);
            sort_model(DIR_ROWS[r].key, DIR_ROWS[r].last, words);
            if (DIR_ROWS[r].typed) begin
                sorted_due.push_back(DIR_ROWS[r].want);
            end else begin
                foreach (words[i])
                    sorted_due.push_back(words[i]);
            end
        end

        // random sets: full store, just over, well over first, then mostly small
        set_i  = 0;
        n_rand = 0;
        while (n_rand < RAND_KEYS) begin
            if (set_i < 3) begin
                size = scripted[set_i];
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    size = $urandom_range(1, 12);
                else if (pick < 9)
                    size = $urandom_range(13, 40);
                else
                    size = $urandom_range(41, MAX_KEYS + 8);
            end
            set_i++;
            src_calm = ($urandom_range(0, 3) == 0);
            pat      = t_key_pat'($urandom_range(0, 3));
            base     = KEY_W'($urandom_range(0, 255));
            for (int j = 0; j < size; j++) begin
                case (pat)
                    PAT_NARROW:  k = base + KEY_W'($urandom_range(0, 3));
                    PAT_EDGE:    k = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    PAT_FALLING: k = 8'(255 - 3 * j);
                    default:     k = KEY_W'($urandom_range(0, 255));
                endcase
                feed_key(k, j == size - 1);
                n_rand++;
            end
        end
        key_if.valid <= 1'b0;

        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Sorted %0d sets from %0d keys (%0d sets overflowed the store)",
                 n_sets, n_keys, n_ovf_sets);
        $display("Checked %0d sorted words, %0d errors", n_words, n_err);
        if (n_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
